### src/fnrq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fnrq_pkg;

    // Default geometry of the node
    localparam int KEYS_DEF        = 8;
    localparam int KEY_BITS_DEF    = 32;
    localparam int SKETCH_BITS_DEF = 8;

    // Fixed field widths
    localparam int VALUE_W = 32;
    localparam int PLEN_W  = 6;

    // Result queue depth, also the bound on queries in flight
    localparam int OUT_DEPTH = 8;

    // Reset value of the key width register
    localparam logic [PLEN_W-1:0] KEY_BITS_RST = 6'd32;

    // Request commands
    typedef enum logic [1:0] {
        CMD_QUERY  = 2'd0,
        CMD_KEY_WR = 2'd1,
        CMD_ANS_WR = 2'd2,
        CMD_COR_WR = 2'd3
    } t_cmd;

    // Configuration register indexes
    localparam logic CFG_SKETCH_MASK = 1'b0;
    localparam logic CFG_KEY_BITS    = 1'b1;

    typedef struct packed {
        t_cmd        cmd;
        logic [2:0]  slot;
        logic [5:0]  column;
        logic [7:0]  sketch_addr;
        logic [31:0] value;
    } t_in_req;

    typedef struct packed {
        logic [2:0] rank;
        logic [2:0] found_slot;
        logic [5:0] prefix_len;
    } t_out_rsp;

    // Result handed from the lookup pipeline to the result queue
    typedef struct packed {
        logic     valid;
        t_out_rsp data;
    } t_push;

endpackage

`default_nettype wire

### src/fnrq_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module fnrq_out_fifo #(
    parameter int DEPTH = fnrq_pkg::OUT_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fnrq_pkg::t_push    i_push,
    input  wire logic               i_pop,
    output fnrq_pkg::t_out_rsp      o_data,
    output logic                    o_valid
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    fnrq_pkg::t_out_rsp r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [CW-1:0] n_cnt;
    logic          w_pop;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_pop   = i_pop && o_valid;

    // Advance pointers, wrapping at the queue depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push.valid) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        unique case ({i_push.valid, w_pop})
            2'b10:   n_cnt = r_cnt + CW'(1);
            2'b01:   n_cnt = r_cnt - CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Store the pushed result
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.data;
        end
    end

endmodule

`default_nettype wire

### src/fusion_node_rank_query_core.sv
// Rank query engine for one fusion-tree node.
// Request channel (i_in_valid / o_in_ready / i_in_data): each request is a
// query or a write of a key, an answer-table entry or a correction entry.
// Writes give no result; each query gives exactly one result on the result
// channel (o_out_valid / i_out_ready / o_out_data), in request order.
// Configuration (i_cfg_we / i_cfg_idx / i_cfg_wdata) sets the sketch mask
// and the key width; write it only while no query is outstanding.
// A query's result passes the answer-table read, the key-store read, the
// difference-length stage, the prefix-length stage with the correction-table
// read, and the result queue; each table is a synchronous read.
// Throughput: one request per cycle, as long as the receiver takes results.
// Results wait in an eight-entry queue; the request side takes new requests
// while fewer than eight queries are in flight or queued, so a stalled
// receiver holds the request side only once that queue is full.
// Reset clears the pipeline, the queue and the configuration (mask 0, key
// width 32). The three tables are not cleared and must be loaded before use.
`timescale 1ns / 1ps
`default_nettype none

module fusion_node_rank_query_core #(
    parameter int KEYS        = fnrq_pkg::KEYS_DEF,
    parameter int KEY_BITS    = fnrq_pkg::KEY_BITS_DEF,
    parameter int SKETCH_BITS = fnrq_pkg::SKETCH_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_idx,
    input  wire logic [31:0]         i_cfg_wdata,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire fnrq_pkg::t_in_req   i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output fnrq_pkg::t_out_rsp       o_out_data
);

    localparam int VW        = fnrq_pkg::VALUE_W;
    localparam int PLW       = fnrq_pkg::PLEN_W;
    localparam int DEPTH     = fnrq_pkg::OUT_DEPTH;
    localparam int CW        = $clog2(DEPTH + 1);
    localparam int KIW       = $clog2(KEYS);
    localparam int SLW       = (KIW > 3) ? KIW : 3;
    localparam int ANS_DEPTH = 1 << SKETCH_BITS;
    localparam int SAW       = (SKETCH_BITS > 8) ? SKETCH_BITS : 8;
    localparam int COR_COLS  = KEY_BITS + 1;
    localparam int COR_DEPTH = KEYS * COR_COLS;
    localparam int CAW       = $clog2(COR_DEPTH);

    // Configuration registers
    logic [VW-1:0]  r_sketch_mask;
    logic [PLW-1:0] r_key_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sketch_mask <= '0;
            r_key_bits    <= fnrq_pkg::KEY_BITS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fnrq_pkg::CFG_SKETCH_MASK: r_sketch_mask <= i_cfg_wdata;
                fnrq_pkg::CFG_KEY_BITS:    r_key_bits    <= i_cfg_wdata[PLW-1:0];
                default:                   r_key_bits    <= r_key_bits;
            endcase
        end
    end

    // Request acceptance and query credit
    logic          w_in_acc;
    logic          w_take;
    logic          w_pop;
    logic [CW-1:0] r_inflight;
    logic [CW-1:0] n_inflight;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_take     = w_in_acc && (i_in_data.cmd == fnrq_pkg::CMD_QUERY);
    assign w_pop      = o_out_valid && i_out_ready;
    assign o_in_ready = (r_inflight < CW'(DEPTH));

    always_comb begin
        n_inflight = r_inflight;
        unique case ({w_take, w_pop})
            2'b10:   n_inflight = r_inflight + CW'(1);
            2'b01:   n_inflight = r_inflight - CW'(1);
            default: n_inflight = r_inflight;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    // ---------------- Stage 0: sketch and answer table ----------------
    // Rank of each mask bit among the set bits below it
    logic [PLW-1:0]         w_pos_cnt [VW];
    logic [SKETCH_BITS-1:0] w_sketch;

    always_comb begin
        for (int i = 0; i < VW; i++) begin
            w_pos_cnt[i] = PLW'($countones(r_sketch_mask & ((VW'(1) << i) - VW'(1))));
        end
    end

    // Gather value bits under the mask, lowest positions first
    always_comb begin
        w_sketch = '0;
        for (int n = 0; n < SKETCH_BITS; n++) begin
            for (int i = 0; i < VW; i++) begin
                w_sketch[n] = w_sketch[n] | (r_sketch_mask[i] && i_in_data.value[i]
                                             && (w_pos_cnt[i] == PLW'(n)));
            end
        end
    end

    logic [2:0]     r_ans_mem [ANS_DEPTH];
    logic [2:0]     r_ans_rd;
    logic [SAW-1:0] w_ans_waddr;
    logic           w_ans_wr;

    assign w_ans_waddr = SAW'(i_in_data.sketch_addr);
    assign w_ans_wr    = w_in_acc && (i_in_data.cmd == fnrq_pkg::CMD_ANS_WR)
                         && ((w_ans_waddr >> SKETCH_BITS) == '0);

    // Answer table: write and look up in the request cycle
    always_ff @(posedge i_clk) begin
        if (w_ans_wr) begin
            r_ans_mem[w_ans_waddr[SKETCH_BITS-1:0]] <= i_in_data.value[2:0];
        end
        r_ans_rd <= r_ans_mem[w_sketch];
    end

    logic              r_s1_valid;
    fnrq_pkg::t_in_req r_s1_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_req <= i_in_data;
    end

    // ---------------- Stage 1: key store ----------------
    logic [SLW-1:0] w_s1_found_ext;
    logic [KIW-1:0] w_s1_found_idx;
    logic           w_s1_found_ok;
    logic [SLW-1:0] w_key_slot_ext;
    logic           w_key_wr;

    assign w_s1_found_ext = SLW'(r_ans_rd);
    assign w_s1_found_idx = w_s1_found_ext[KIW-1:0];
    assign w_s1_found_ok  = (int'(r_ans_rd) < KEYS);
    assign w_key_slot_ext = SLW'(r_s1_req.slot);
    assign w_key_wr       = r_s1_valid && (r_s1_req.cmd == fnrq_pkg::CMD_KEY_WR)
                            && (int'(r_s1_req.slot) < KEYS);

    logic [VW-1:0] r_key_mem [KEYS];
    logic [VW-1:0] r_key_rd;

    // Key store: writes land in the stage that reads, keeping request order
    always_ff @(posedge i_clk) begin
        if (w_key_wr) begin
            r_key_mem[w_key_slot_ext[KIW-1:0]] <= r_s1_req.value;
        end
        r_key_rd <= r_key_mem[w_s1_found_idx];
    end

    logic              r_s2_valid;
    fnrq_pkg::t_in_req r_s2_req;
    logic [2:0]        r_s2_found;
    logic              r_s2_found_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_req      <= r_s1_req;
        r_s2_found    <= r_ans_rd;
        r_s2_found_ok <= w_s1_found_ok;
    end

    // ---------------- Stage 2: difference bit length ----------------
    logic [VW-1:0]  w_key;
    logic [VW-1:0]  w_diff;
    logic [PLW-1:0] w_len;

    assign w_key  = r_s2_found_ok ? r_key_rd : '0;
    assign w_diff = w_key ^ r_s2_req.value;

    always_comb begin
        w_len = '0;
        for (int i = 0; i < VW; i++) begin
            if (w_diff[i]) begin
                w_len = PLW'(i + 1);
            end
        end
    end

    logic              r_s3_valid;
    fnrq_pkg::t_in_req r_s3_req;
    logic [2:0]        r_s3_found;
    logic              r_s3_found_ok;
    logic [PLW-1:0]    r_s3_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_req      <= r_s2_req;
        r_s3_found    <= r_s2_found;
        r_s3_found_ok <= r_s2_found_ok;
        r_s3_len      <= w_len;
    end

    // ---------------- Stage 3: prefix length and correction table ----------
    logic [PLW-1:0] w_kb;
    logic [PLW-1:0] w_prefix;
    logic [SLW-1:0] w_s3_found_ext;
    logic [SLW-1:0] w_cor_slot_ext;
    logic [CAW-1:0] w_cor_raddr;
    logic [CAW-1:0] w_cor_waddr;
    logic           w_cor_wr;

    // Limit key width, clamp a negative prefix to zero
    assign w_kb     = (int'(r_key_bits) > KEY_BITS) ? PLW'(KEY_BITS) : r_key_bits;
    assign w_prefix = (r_s3_len >= w_kb) ? '0 : w_kb - r_s3_len;

    assign w_s3_found_ext = SLW'(r_s3_found);
    assign w_cor_slot_ext = SLW'(r_s3_req.slot);
    assign w_cor_raddr    = CAW'(w_s3_found_ext[KIW-1:0]) * CAW'(COR_COLS) + CAW'(w_prefix);
    assign w_cor_waddr    = CAW'(w_cor_slot_ext[KIW-1:0]) * CAW'(COR_COLS)
                            + CAW'(r_s3_req.column);
    assign w_cor_wr       = r_s3_valid && (r_s3_req.cmd == fnrq_pkg::CMD_COR_WR)
                            && (int'(r_s3_req.slot) < KEYS)
                            && (int'(r_s3_req.column) <= KEY_BITS);

    logic [2:0] r_cor_mem [COR_DEPTH];
    logic [2:0] r_cor_rd;

    always_ff @(posedge i_clk) begin
        if (w_cor_wr) begin
            r_cor_mem[w_cor_waddr] <= r_s3_req.value[2:0];
        end
        r_cor_rd <= r_cor_mem[w_cor_raddr];
    end

    logic           r_s4_valid;
    logic [2:0]     r_s4_found;
    logic           r_s4_found_ok;
    logic [PLW-1:0] r_s4_prefix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else begin
            r_s4_valid <= r_s3_valid && (r_s3_req.cmd == fnrq_pkg::CMD_QUERY);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_found    <= r_s3_found;
        r_s4_found_ok <= r_s3_found_ok;
        r_s4_prefix   <= w_prefix;
    end

    // ---------------- Stage 4: result into the queue ----------------
    fnrq_pkg::t_push w_push;

    always_comb begin
        w_push.valid           = r_s4_valid;
        w_push.data.rank       = r_s4_found_ok ? r_cor_rd : 3'd0;
        w_push.data.found_slot = r_s4_found;
        w_push.data.prefix_len = r_s4_prefix;
    end

    fnrq_out_fifo #(
        .DEPTH (DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (i_out_ready),
        .o_data  (o_out_data),
        .o_valid (o_out_valid)
    );

endmodule

`default_nettype wire

### src/fnrq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module fnrq_checker #(
    parameter int KEY_BITS = fnrq_pkg::KEY_BITS_DEF
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire fnrq_pkg::t_in_req  i_in_data,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire fnrq_pkg::t_out_rsp o_out_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result dropped or changed while stalled");

    // Drop all results at reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

    // A result rising from an empty queue comes from a query that went straight through the pipeline
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |->
            $past(i_in_valid && o_in_ready && (i_in_data.cmd == fnrq_pkg::CMD_QUERY), 5))
        else $error("result without a matching query");

    // Prefix length never exceeds the key width
    a_prefix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (int'(o_out_data.prefix_len) <= KEY_BITS))
        else $error("prefix length out of range");

endmodule

bind fusion_node_rank_query_core fnrq_checker #(
    .KEY_BITS (KEY_BITS)
) u_fnrq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
